// ===== hw/rtl/ucaf_pkg.sv =====
// Shared types and constants of the UTF-8 CJK / alphanumeric filter.
// No dependencies; imported by every file of the block but ucaf_ifs.
package ucaf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Progress through a candidate three-byte ideograph.
  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // One queue entry holds every result that a single input word causes.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       eos;
  } entry_t;

  // Write request from the front end into the queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } qwr_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       run_last;
  } result_t;

endpackage

// ===== hw/rtl/ucaf_ifs.sv =====
// Valid/ready channel interfaces of the filter: byte input and result output.
// No dependencies.
interface ucaf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink (input valid, input in_byte, input string_last, output ready);
endinterface

interface ucaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output has_byte, output string_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input string_end,
                input run_last, output ready);
endinterface

// ===== hw/rtl/ucaf_front.sv =====
// Front end: accepts input words, tracks skip and ideograph state, builds queue entries.
// Depends on ucaf_pkg and ucaf_in_if.
module ucaf_front (
  input  logic            clk,
  input  logic            rst_n,
  ucaf_in_if.sink         in_ch,
  input  logic            q_full,
  output ucaf_pkg::qwr_t  q_wr
);
  import ucaf_pkg::*;

  logic [2:0] skip_r, skip_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] second_r, second_nxt;
  logic       accept;
  logic [7:0] b;

  function automatic logic is_alnum(input logic [7:0] v);
    return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5A) ||
           (v >= 8'h61 && v <= 8'h7A);
  endfunction

  function automatic logic ideograph_ok(input logic [7:0] lead, input logic [7:0] b1,
                                        input logic [7:0] b2);
    logic [7:0] lo1, hi1, hi2;
    lo1 = 8'h80;
    hi1 = 8'hBF;
    hi2 = 8'hBF;
    if (lead == 8'hE4) begin
      lo1 = 8'hB8;
    end else if (lead == 8'hE9) begin
      hi1 = 8'hBE;
      if (b1 == 8'hBE) begin
        hi2 = 8'hA5;
      end
    end
    return b1 >= lo1 && b1 <= hi1 && b2 >= 8'h80 && b2 <= hi2;
  endfunction

  assign b           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Next state.
  always_comb begin
    skip_nxt   = skip_r;
    phase_nxt  = phase_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    if (skip_r != 3'd0) begin
      skip_nxt = skip_r - 3'd1;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          second_nxt = b;
          phase_nxt  = PH_SECOND;
        end
        PH_SECOND: begin
          phase_nxt = PH_NONE;
        end
        PH_NONE: begin
          if (b < 8'hC0) begin
            skip_nxt = 3'd0;
          end else if (b < 8'hE0) begin
            skip_nxt = 3'd1;
          end else if (b < 8'hF0) begin
            if (b >= 8'hE4 && b <= 8'hE9) begin
              lead_nxt  = b;
              phase_nxt = PH_LEAD;
            end else begin
              skip_nxt = 3'd2;
            end
          end else if (b < 8'hF8) begin
            skip_nxt = 3'd3;
          end else if (b < 8'hFC) begin
            skip_nxt = 3'd4;
          end else if (b < 8'hFE) begin
            skip_nxt = 3'd5;
          end
        end
        default: begin
          phase_nxt = PH_NONE;
        end
      endcase
    end
    if (in_ch.string_last) begin
      skip_nxt   = 3'd0;
      phase_nxt  = PH_NONE;
      lead_nxt   = 8'h00;
      second_nxt = 8'h00;
    end
  end

  // Queue entry for this word.
  always_comb begin
    q_wr.entry.b0     = b;
    q_wr.entry.b1     = 8'h00;
    q_wr.entry.b2     = 8'h00;
    q_wr.entry.nbytes = 2'd0;
    q_wr.entry.eos    = in_ch.string_last;
    if (skip_r == 3'd0) begin
      unique case (phase_r)
        PH_SECOND: begin
          q_wr.entry.b0 = lead_r;
          q_wr.entry.b1 = second_r;
          q_wr.entry.b2 = b;
          if (ideograph_ok(lead_r, second_r, b)) begin
            q_wr.entry.nbytes = 2'd3;
          end
        end
        PH_NONE: begin
          if (b < 8'hC0 && is_alnum(b)) begin
            q_wr.entry.nbytes = 2'd1;
          end
        end
        default: begin
          q_wr.entry.nbytes = 2'd0;
        end
      endcase
    end
    q_wr.push = accept && (q_wr.entry.nbytes != 2'd0 || in_ch.string_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= 3'd0;
      phase_r  <= PH_NONE;
      lead_r   <= 8'h00;
      second_r <= 8'h00;
    end else if (accept) begin
      skip_r   <= skip_nxt;
      phase_r  <= phase_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== hw/rtl/ucaf_queue.sv =====
// Small first-in first-out queue of result groups between front and back end.
// Depends on ucaf_pkg.
module ucaf_queue #(
  parameter int unsigned Depth = ucaf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ucaf_pkg::qwr_t   q_wr,
  output logic             q_full,
  output logic             q_valid,
  output ucaf_pkg::entry_t q_entry,
  input  logic             q_pop
);
  import ucaf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign q_full  = (cnt_r == CntW'(Depth));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ucaf_back.sv =====
// Back end: walks the head entry, one result word per cycle unless stalled, into res_r.
// Depends on ucaf_pkg and ucaf_out_if.
module ucaf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ucaf_pkg::entry_t q_entry,
  output logic             q_pop,
  ucaf_out_if.source       out_ch
);
  import ucaf_pkg::*;

  logic [1:0] idx_r;
  logic       out_vld_r;
  result_t    res_r, res_nxt;
  logic       load, emit, last;
  logic [2:0] total;

  assign load  = !out_vld_r || out_ch.ready;
  assign emit  = q_valid && load;
  assign total = {1'b0, q_entry.nbytes} + {2'b00, q_entry.eos};
  assign last  = ({1'b0, idx_r} == total - 3'd1);
  assign q_pop = emit && last;

  always_comb begin
    res_nxt.run_last = last;
    if (idx_r < q_entry.nbytes) begin
      res_nxt.has_byte   = 1'b1;
      res_nxt.string_end = 1'b0;
      case (idx_r)
        2'd0:    res_nxt.out_byte = q_entry.b0;
        2'd1:    res_nxt.out_byte = q_entry.b1;
        default: res_nxt.out_byte = q_entry.b2;
      endcase
    end else begin
      res_nxt.has_byte   = 1'b0;
      res_nxt.string_end = 1'b1;
      res_nxt.out_byte   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (emit) begin
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end
      if (load) begin
        out_vld_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_byte   = res_r.out_byte;
  assign out_ch.has_byte   = res_r.has_byte;
  assign out_ch.string_end = res_r.string_end;
  assign out_ch.run_last   = res_r.run_last;

endmodule

// ===== hw/rtl/utf8_cjk_alnum_filter_unit.sv =====
// Top level of the UTF-8 CJK ideograph and alphanumeric filter.
// Depends on ucaf_pkg, ucaf_ifs, ucaf_front, ucaf_queue and ucaf_back.
//
//   channel   dir   handshake               word contents
//   in_ch     in    valid/ready             in_byte, string_last
//   out_ch    out   valid/ready             out_byte, has_byte, string_end, run_last
//
// One input word is accepted per cycle whenever the queue has room; a result word
// leaves per cycle while the receiver is ready, so the output rate is set by the
// single output register. Reset is synchronous and active low; it empties the
// queue and clears the control state, but not the stored entries or result data.
// Either side may stall: the queue of QDepth result groups decouples the two, and a
// three-byte ideograph burst drains word by word while input keeps flowing in.
module utf8_cjk_alnum_filter_unit #(
  parameter int unsigned QDepth = ucaf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ucaf_in_if.sink     in_ch,
  ucaf_out_if.source  out_ch
);
  import ucaf_pkg::*;

  // Write request from the classifier into the queue.
  qwr_t   q_wr;
  logic   q_full;
  // Head of the queue as seen by the serializer.
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  // The front end classifies every byte and decides, in the cycle of acceptance,
  // which results that byte causes. Words without any result only update state.
  ucaf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Each queue entry carries all results of one input word: up to three data
  // bytes and an optional end marker.
  ucaf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // The back end splits the head entry into single result words and marks the
  // final one of each group with run_last.
  ucaf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== test/utf8_cjk_alnum_filter_unit_test.sv =====
// Self-checking testbench of the UTF-8 CJK ideograph and alphanumeric filter.
// Depends on ucaf_pkg, the channel interfaces in ucaf_ifs and the filter's RTL.
// It runs a directed table and then random strings, all checked word by word.
module utf8_cjk_alnum_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ucaf_pkg::*;

  // Byte classes of UTF-8 and the window of kept ideographs, U+4E00..U+9FA5.
  localparam logic [7:0] CONT_MIN         = 8'h80;
  localparam logic [7:0] CONT_MAX         = 8'hBF;
  localparam logic [7:0] CJK_LEAD_FIRST   = 8'hE4;
  localparam logic [7:0] CJK_LEAD_LAST    = 8'hE9;
  localparam logic [7:0] CJK_FIRST_SECOND = 8'hB8;
  localparam logic [7:0] CJK_LAST_SECOND  = 8'hBE;
  localparam logic [7:0] CJK_LAST_THIRD   = 8'hA5;

  localparam int RANDOM_WORDS = 350;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  // How the expectation of a directed row is formed: from the predictor, or
  // typed into the table as no result at all or as exactly one result word.
  typedef enum logic [1:0] {
    BY_MODEL   = 2'd0,
    NO_RESULT  = 2'd1,
    ONE_RESULT = 2'd2
  } check_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    check_t     check;
    result_t    want;
  } stim_row_t;

  localparam result_t NOTHING  = '0;
  localparam result_t END_MARK = '{8'h00, 1'b0, 1'b1, 1'b1};

  // The directed part. Single ASCII bytes and string ends are typed in; the
  // multi-byte forms are left to the predictor.
  localparam int DIRECTED_ROWS = 26;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, NO_RESULT,  NOTHING},
    '{8'h30, 1'b0, ONE_RESULT, '{8'h30, 1'b1, 1'b0, 1'b1}},
    '{8'h39, 1'b0, ONE_RESULT, '{8'h39, 1'b1, 1'b0, 1'b1}},
    '{8'h41, 1'b0, ONE_RESULT, '{8'h41, 1'b1, 1'b0, 1'b1}},
    '{8'h5A, 1'b0, ONE_RESULT, '{8'h5A, 1'b1, 1'b0, 1'b1}},
    '{8'h61, 1'b0, ONE_RESULT, '{8'h61, 1'b1, 1'b0, 1'b1}},
    '{8'h7A, 1'b0, ONE_RESULT, '{8'h7A, 1'b1, 1'b0, 1'b1}},
    '{8'h2F, 1'b0, NO_RESULT,  NOTHING},
    '{8'h7B, 1'b0, NO_RESULT,  NOTHING},
    '{8'h80, 1'b0, NO_RESULT,  NOTHING},   // stray continuation byte
    '{8'hFF, 1'b0, NO_RESULT,  NOTHING},
    '{8'hFE, 1'b1, ONE_RESULT, END_MARK},
    '{8'hC3, 1'b0, BY_MODEL,   NOTHING},   // two-byte lead ...
    '{8'h41, 1'b0, BY_MODEL,   NOTHING},   // ... swallows a letter
    '{8'hE4, 1'b0, BY_MODEL,   NOTHING},   // first ideograph, U+4E00
    '{8'hB8, 1'b0, BY_MODEL,   NOTHING},
    '{8'h80, 1'b0, BY_MODEL,   NOTHING},
    '{8'hE9, 1'b0, BY_MODEL,   NOTHING},   // one past the last ideograph
    '{8'hBE, 1'b0, BY_MODEL,   NOTHING},
    '{8'hA6, 1'b0, BY_MODEL,   NOTHING},
    '{8'hE9, 1'b0, BY_MODEL,   NOTHING},   // last ideograph, U+9FA5, ending the string
    '{8'hBE, 1'b0, BY_MODEL,   NOTHING},
    '{8'hA5, 1'b1, BY_MODEL,   NOTHING},
    '{8'hF8, 1'b0, BY_MODEL,   NOTHING},   // five-byte lead, cut short by the string end
    '{8'hE4, 1'b1, ONE_RESULT, END_MARK},
    '{8'h7A, 1'b1, BY_MODEL,   NOTHING}    // kept letter plus end marker
  };

  logic clk;
  logic rst_n;

  ucaf_in_if  in_ch ();
  ucaf_out_if out_ch ();

  utf8_cjk_alnum_filter_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: bytes still to skip, progress through a candidate
  // ideograph and the two bytes held for it.
  logic [2:0] skip_left;
  phase_t     phase;
  logic [7:0] lead_byte;
  logic [7:0] second_byte;

  // Result words of the input word just accepted, oldest first.
  result_t burst [4];
  int      burst_n;

  // Result words still due from the block, oldest at the front.
  result_t awaited_words [$];

  // Checking mode of the word on the input channel, set along with its data.
  check_t  row_check;
  result_t row_want;

  int mismatch_count;
  int cycle_count;
  int random_sent;
  int steady_left;

  function automatic result_t make_result(input logic [7:0] b, input logic has,
                                          input logic eos);
    result_t r;
    r.out_byte   = b;
    r.has_byte   = has;
    r.string_end = eos;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // Advances the predictor by one input word and leaves its results in burst.
  function automatic void filter_byte(input logic [7:0] b, input logic last);
    logic [7:0] lo1;
    logic [7:0] hi1;
    logic [7:0] hi2;
    burst_n = 0;
    if (skip_left != 3'd0) begin
      skip_left = skip_left - 3'd1;
    end else if (phase == PH_LEAD) begin
      second_byte = b;
      phase = PH_SECOND;
    end else if (phase == PH_SECOND) begin
      // The lead byte narrows the window of the second byte at both ends of
      // the range, and the very last lead narrows the third byte too.
      lo1 = (lead_byte == CJK_LEAD_FIRST) ? CJK_FIRST_SECOND : CONT_MIN;
      hi1 = (lead_byte == CJK_LEAD_LAST) ? CJK_LAST_SECOND : CONT_MAX;
      hi2 = (lead_byte == CJK_LEAD_LAST && second_byte == CJK_LAST_SECOND) ?
            CJK_LAST_THIRD : CONT_MAX;
      if (second_byte >= lo1 && second_byte <= hi1 && b >= CONT_MIN && b <= hi2) begin
        burst[0] = make_result(lead_byte, 1'b1, 1'b0);
        burst[1] = make_result(second_byte, 1'b1, 1'b0);
        burst[2] = make_result(b, 1'b1, 1'b0);
        burst_n = 3;
      end
      phase = PH_NONE;
    end else if (b < 8'hC0) begin
      if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        burst[0] = make_result(b, 1'b1, 1'b0);
        burst_n = 1;
      end
    end else if (b < 8'hE0) begin
      skip_left = 3'd1;
    end else if (b < 8'hF0) begin
      if (b >= CJK_LEAD_FIRST && b <= CJK_LEAD_LAST) begin
        lead_byte = b;
        phase = PH_LEAD;
      end else begin
        skip_left = 3'd2;
      end
    end else if (b < 8'hF8) begin
      skip_left = 3'd3;
    end else if (b < 8'hFC) begin
      skip_left = 3'd4;
    end else if (b < 8'hFE) begin
      skip_left = 3'd5;
    end
    // The last byte of a string drops whatever is pending and adds the marker.
    if (last) begin
      skip_left = 3'd0;
      phase = PH_NONE;
      lead_byte = 8'h00;
      second_byte = 8'h00;
      burst[burst_n] = make_result(8'h00, 1'b0, 1'b1);
      burst_n++;
    end
    if (burst_n > 0) burst[burst_n - 1].run_last = 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected byte %02h has %b end %b last %b,",
               $realtime, what, want.out_byte, want.has_byte, want.string_end,
               want.run_last);
      $display("    got byte %02h has %b end %b last %b",
               got.out_byte, got.has_byte, got.string_end, got.run_last);
    end
  endfunction

  // Following byte of a multi-byte form: mostly a real continuation byte, but
  // sometimes anything, since skipped and taken bytes are consumed blindly.
  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off if it takes far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still due", cycle_count,
               awaited_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Watches both channels at every edge. The predictor runs on the accepted
  // input word first, so an expectation is always queued before any word of
  // the output channel could answer it.
  always @(posedge clk) begin : watch_ports
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        filter_byte(in_ch.in_byte, in_ch.string_last);
        case (row_check)
          BY_MODEL: begin
            for (int i = 0; i < burst_n; i++) awaited_words.push_back(burst[i]);
          end
          ONE_RESULT: awaited_words.push_back(row_want);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte   = out_ch.out_byte;
        got.has_byte   = out_ch.has_byte;
        got.string_end = out_ch.string_end;
        got.run_last   = out_ch.run_last;
        if (awaited_words.size() == 0) begin
          note_mismatch("unexpected word", NOTHING, got);
        end else begin
          want = awaited_words.pop_front();
          // Every field is compared; an end marker carries a zero byte.
          if (got !== want) begin
            note_mismatch("mismatch", want, got);
          end
        end
      end
    end
  end

  // Receiver: the ready line toggles with mostly short stalls, a few long ones,
  // and now and then a long stretch in which it stays high.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12))
        @(posedge clk);
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(0, 6) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  end

  // Offers one word after a random gap and returns at the edge that accepts it.
  // A word that follows without a gap keeps valid high throughout.
  task automatic send_word(input logic [7:0] b, input logic last, input check_t check,
                           input result_t want);
    int gap;
    int r;
    gap = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) steady_left = $urandom_range(10, 40);
      else if (r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.string_last <= last;
    row_check         <= check;
    row_want          <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the input back until every expected word has come out. The first
  // edge lets the watcher queue the results of a word accepted just before.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // One random string built from whole UTF-8 forms with random content. Most
  // strings end after their last form; some are cut short at a random byte.
  task automatic send_string();
    logic [7:0] text [$];
    logic [15:0] cp;
    int tokens;
    int r;
    int cut_at;
    tokens = $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        r = $urandom_range(0, 61);
        if (r < 10) text.push_back(8'("0" + r));
        else if (r < 36) text.push_back(8'("A" + r - 10));
        else text.push_back(8'("a" + r - 36));
      end else if (r < 45) begin
        r = $urandom_range(0, 9);
        if (r == 0) cp = 16'h4E00;
        else if (r == 1) cp = 16'h9FA5;
        else cp = 16'($urandom_range(16'h4E00, 16'h9FA5));
        text.push_back({4'hE, cp[15:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end else if (r < 53) begin
        // Candidates that fail the range check, mostly just outside it.
        case ($urandom_range(0, 3))
          0: begin
            text.push_back(CJK_LEAD_FIRST);
            text.push_back(8'($urandom_range(8'h80, 8'hB7)));
            text.push_back(follow_byte());
          end
          1: begin
            text.push_back(CJK_LEAD_LAST);
            text.push_back(CJK_LAST_SECOND);
            text.push_back(8'($urandom_range(8'hA6, 8'hBF)));
          end
          2: begin
            text.push_back(CJK_LEAD_LAST);
            text.push_back(CONT_MAX);
            text.push_back(follow_byte());
          end
          default: begin
            text.push_back(8'($urandom_range(CJK_LEAD_FIRST, CJK_LEAD_LAST)));
            text.push_back(8'($urandom_range(0, 255)));
            text.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end else if (r < 61) begin
        text.push_back(8'($urandom_range(0, 8'hBF)));
      end else if (r < 67) begin
        text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        text.push_back(follow_byte());
      end else if (r < 73) begin
        text.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hE3)) :
                                              8'($urandom_range(8'hEA, 8'hEF)));
        repeat (2) text.push_back(follow_byte());
      end else if (r < 79) begin
        text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        repeat (3) text.push_back(follow_byte());
      end else if (r < 84) begin
        text.push_back(8'($urandom_range(8'hF8, 8'hFB)));
        repeat (4) text.push_back(follow_byte());
      end else if (r < 88) begin
        text.push_back(8'($urandom_range(8'hFC, 8'hFD)));
        repeat (5) text.push_back(follow_byte());
      end else if (r < 92) begin
        text.push_back(8'($urandom_range(8'hFE, 8'hFF)));
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    cut_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, text.size() - 1) :
                                            text.size() - 1;
    for (int i = 0; i <= cut_at; i++) begin
      send_word(text[i], i == cut_at, BY_MODEL, NOTHING);
    end
    random_sent += cut_at + 1;
  endtask

  initial begin
    logic paused;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.string_last <= 1'b0;
    row_check         <= BY_MODEL;
    row_want          <= NOTHING;
    skip_left      = 3'd0;
    phase          = PH_NONE;
    lead_byte      = 8'h00;
    second_byte    = 8'h00;
    burst_n        = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    random_sent    = 0;
    steady_left    = 0;
    paused         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(DIRECTED[i].b, DIRECTED[i].last, DIRECTED[i].check, DIRECTED[i].want);
    end
    wait_drained();

    // Random strings; halfway through the sender waits for the output to run dry.
    while (random_sent < RANDOM_WORDS) begin
      if (!paused && random_sent >= RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_string();
    end

    // Any word that arrives now is unexpected and is caught by the watcher.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
